/* sv/sound_activity_detector_unit_macros.svh */
// Assertion macros for the sound activity detector.
`ifndef SOUND_ACTIVITY_DETECTOR_UNIT_MACROS_SVH
`define SOUND_ACTIVITY_DETECTOR_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define SAD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sound activity detector check failed");
// next-cycle implication, checked out of reset
`define SAD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sound activity detector check failed");
`else
`define SAD_ASSERT_NOW(label, ante, cons)
`define SAD_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* sv/sad_pkg.sv */
// Shared types and constants of the sound activity detector.
package sad_pkg;

  localparam int PWR_W   = 16;
  localparam int TIME_W  = 32;
  localparam int INTEG_W = 32;
  localparam int STEP_W  = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  // quotient bits: |step| * diff stays below 2^31
  localparam int DIV_STEPS = 31;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // detector states
  localparam logic [1:0] ST_SILENCE = 2'd0;
  localparam logic [1:0] ST_SOUND   = 2'd1;
  localparam logic [1:0] ST_LASTING = 2'd2;

  // register map
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOUND_STEP = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIL_STEP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FLOOR      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CEILING    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ON_LEVEL   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_LEVEL  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_LASTING_MS = 3'd7;

  // register reset values
  localparam logic [PWR_W-1:0]          RST_THRESHOLD  = 16'd1311;
  localparam logic signed [STEP_W-1:0]  RST_SOUND_STEP = 16'sd100;
  localparam logic signed [STEP_W-1:0]  RST_SIL_STEP   = -16'sd100;
  localparam logic signed [INTEG_W-1:0] RST_FLOOR      = 32'sd0;
  localparam logic signed [INTEG_W-1:0] RST_CEILING    = 32'sd1000;
  localparam logic signed [INTEG_W-1:0] RST_ON_LEVEL   = 32'sd500;
  localparam logic signed [INTEG_W-1:0] RST_OFF_LEVEL  = 32'sd100;
  localparam logic [TIME_W-1:0]         RST_LASTING_MS = 32'd120000;

  typedef struct packed {
    logic [PWR_W-1:0]  power;
    logic [TIME_W-1:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [1:0]                  sound_state;
    logic                        state_changed;
    logic signed [INTEG_W-1:0]   integrator_value;
  } out_item_t;

endpackage

/* sv/sound_activity_detector_unit.sv */
// Sound activity detector: power integrator with hysteresis and lasting-silence timer.
//
// Each request carries a power sample (unsigned Q0.16) and a millisecond
// timestamp. Power at or above the threshold T adds sound_step*(p-T)/T to a
// signed integrator, power below it adds silence_step*(T-p)/T; the quotient
// truncates toward zero and a threshold of zero acts as one. The integrator
// is clamped to the floor, then to the ceiling (the ceiling wins if they
// cross). A three-state detector (silence, sound, lasting silence) then
// moves at most once per request: to sound when the integrator reaches the
// on level, back to silence when it falls to the off level (starting the
// silence timer), and to lasting silence once the wrapped time since that
// start reaches lasting_silence_ms. The timer runs from time 0 after reset.
// Every request yields exactly one result: new state, a change flag and the
// clamped integrator. A request is taken in the idle step, then passes a
// multiply step, the bit-serial restoring divider (31 quotient bits, one
// quotient bit per cycle through a single 17-bit subtractor), an add step
// and a finish step; a new request waits until the last one has finished.
// in_ready comes back at the same time as the result becomes valid. The
// result sits in an output register, so a new request may be taken while
// the last result waits; the finish step holds until that register is
// free. Registers are written through the cfg port; the user must write
// them only while no request is in flight, which the block does not
// enforce; cfg_ready is always high.
`include "sound_activity_detector_unit_macros.svh"

module sound_activity_detector_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  sad_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output sad_pkg::out_item_t             out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sad_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sad_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sad_pkg::*;

  // sequencer codes
  localparam logic [2:0] SQ_IDLE = 3'd0;
  localparam logic [2:0] SQ_MUL  = 3'd1;
  localparam logic [2:0] SQ_DIV  = 3'd2;
  localparam logic [2:0] SQ_ADD  = 3'd3;
  localparam logic [2:0] SQ_FIN  = 3'd4;

  // configuration registers
  logic [PWR_W-1:0]          thr_r;
  logic signed [STEP_W-1:0]  snd_step_r;
  logic signed [STEP_W-1:0]  sil_step_r;
  logic signed [INTEG_W-1:0] floor_r;
  logic signed [INTEG_W-1:0] ceil_r;
  logic signed [INTEG_W-1:0] on_lvl_r;
  logic signed [INTEG_W-1:0] off_lvl_r;
  logic [TIME_W-1:0]         last_ms_r;

  // sequencer and datapath
  logic [2:0]                seq_r, seq_nxt;
  logic [PWR_W-1:0]          pwr_r, pwr_nxt;
  logic [TIME_W-1:0]         now_r, now_nxt;
  logic                      neg_r, neg_nxt;
  logic [DIV_STEPS-1:0]      dvd_r, dvd_nxt;     // dividend, becomes quotient
  logic [PWR_W-1:0]          rem_r, rem_nxt;
  logic [DIV_CNT_W-1:0]      cnt_r, cnt_nxt;
  logic signed [INTEG_W:0]   acc_r, acc_nxt;     // 33 bits: sum never wraps

  // detector state
  logic signed [INTEG_W-1:0] integ_r, integ_nxt;
  logic [1:0]                dstate_r, dstate_nxt;
  logic [TIME_W-1:0]         sil_start_r, sil_start_nxt;

  // output register
  logic                      out_valid_r, out_valid_nxt;
  out_item_t                 out_data_r, out_data_nxt;

  // combinational helpers
  logic [PWR_W-1:0]          thr_eff;
  logic                      above;
  logic [PWR_W-1:0]          diff;
  logic signed [STEP_W-1:0]  step_sel;
  logic [STEP_W:0]           step_mag;
  logic [2*STEP_W:0]         prod;
  logic [PWR_W:0]            shifted;
  logic [PWR_W:0]            trial;
  logic                      q_bit;
  logic signed [INTEG_W:0]   mag;
  logic signed [INTEG_W:0]   delta;
  logic signed [INTEG_W:0]   lo_ext;
  logic signed [INTEG_W:0]   hi_ext;
  logic signed [INTEG_W:0]   clamp_lo;
  logic signed [INTEG_W:0]   clamp_hi;
  logic signed [INTEG_W-1:0] integ_new;
  logic [TIME_W-1:0]         elapsed;
  logic                      out_free;

  assign in_ready  = (seq_r == SQ_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || out_ready;

  // threshold of zero behaves as one
  assign thr_eff  = (thr_r == '0) ? PWR_W'(1) : thr_r;
  assign above    = (pwr_r >= thr_eff);
  assign diff     = above ? (pwr_r - thr_eff) : (thr_eff - pwr_r);
  assign step_sel = above ? snd_step_r : sil_step_r;
  // magnitude of the gain; 32768 for -32768 still fits in the low 16 bits
  assign step_mag = step_sel[STEP_W-1] ? ((STEP_W+1)'(0) - {step_sel[STEP_W-1], step_sel})
                                       : {1'b0, step_sel};
  assign prod     = step_mag * {{(STEP_W+1-PWR_W){1'b0}}, diff};

  // restoring divide step
  assign shifted = {rem_r, dvd_r[DIV_STEPS-1]};
  assign trial   = shifted - {1'b0, thr_eff};
  assign q_bit   = (shifted >= {1'b0, thr_eff});

  assign mag     = {{(INTEG_W+1-DIV_STEPS){1'b0}}, dvd_r};
  assign delta   = neg_r ? -mag : mag;

  // clamp: floor first, ceiling last
  assign lo_ext    = {floor_r[INTEG_W-1], floor_r};
  assign hi_ext    = {ceil_r[INTEG_W-1], ceil_r};
  assign clamp_lo  = (acc_r < lo_ext) ? lo_ext : acc_r;
  assign clamp_hi  = (clamp_lo > hi_ext) ? hi_ext : clamp_lo;
  assign integ_new = clamp_hi[INTEG_W-1:0];
  assign elapsed   = now_r - sil_start_r;

  always_comb begin
    seq_nxt       = seq_r;
    pwr_nxt       = pwr_r;
    now_nxt       = now_r;
    neg_nxt       = neg_r;
    dvd_nxt       = dvd_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    acc_nxt       = acc_r;
    integ_nxt     = integ_r;
    dstate_nxt    = dstate_r;
    sil_start_nxt = sil_start_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;

    case (seq_r)
      SQ_IDLE: begin
        if (in_valid) begin
          pwr_nxt = in_data.power;
          now_nxt = in_data.now_ms;
          seq_nxt = SQ_MUL;
        end
      end
      SQ_MUL: begin
        // |gain| * |p - T| < 2^31
        dvd_nxt = prod[DIV_STEPS-1:0];
        neg_nxt = step_sel[STEP_W-1];
        rem_nxt = '0;
        cnt_nxt = '0;
        seq_nxt = SQ_DIV;
      end
      SQ_DIV: begin
        rem_nxt = q_bit ? trial[PWR_W-1:0] : shifted[PWR_W-1:0];
        dvd_nxt = {dvd_r[DIV_STEPS-2:0], q_bit};
        if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          seq_nxt = SQ_ADD;
        end else begin
          cnt_nxt = cnt_r + DIV_CNT_W'(1);
        end
      end
      SQ_ADD: begin
        acc_nxt = {integ_r[INTEG_W-1], integ_r} + delta;
        seq_nxt = SQ_FIN;
      end
      SQ_FIN: begin
        // hold until the output register can take the result
        if (out_free) begin
          integ_nxt = integ_new;
          out_data_nxt.state_changed = 1'b0;
          if ((dstate_r == ST_SILENCE || dstate_r == ST_LASTING) &&
              integ_new >= on_lvl_r) begin
            dstate_nxt = ST_SOUND;
            out_data_nxt.state_changed = 1'b1;
          end else if (dstate_r == ST_SOUND && integ_new <= off_lvl_r) begin
            dstate_nxt    = ST_SILENCE;
            sil_start_nxt = now_r;
            out_data_nxt.state_changed = 1'b1;
          end else if (dstate_r == ST_SILENCE && elapsed >= last_ms_r) begin
            dstate_nxt = ST_LASTING;
            out_data_nxt.state_changed = 1'b1;
          end
          out_data_nxt.sound_state      = dstate_nxt;
          out_data_nxt.integrator_value = integ_new;
          out_valid_nxt = 1'b1;
          seq_nxt       = SQ_IDLE;
        end
      end
      default: begin
        seq_nxt = SQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r       <= SQ_IDLE;
      out_valid_r <= 1'b0;
      integ_r     <= '0;
      dstate_r    <= ST_SILENCE;
      sil_start_r <= '0;
    end else begin
      seq_r       <= seq_nxt;
      out_valid_r <= out_valid_nxt;
      integ_r     <= integ_nxt;
      dstate_r    <= dstate_nxt;
      sil_start_r <= sil_start_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    pwr_r      <= pwr_nxt;
    now_r      <= now_nxt;
    neg_r      <= neg_nxt;
    dvd_r      <= dvd_nxt;
    rem_r      <= rem_nxt;
    cnt_r      <= cnt_nxt;
    acc_r      <= acc_nxt;
    out_data_r <= out_data_nxt;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r      <= RST_THRESHOLD;
      snd_step_r <= RST_SOUND_STEP;
      sil_step_r <= RST_SIL_STEP;
      floor_r    <= RST_FLOOR;
      ceil_r     <= RST_CEILING;
      on_lvl_r   <= RST_ON_LEVEL;
      off_lvl_r  <= RST_OFF_LEVEL;
      last_ms_r  <= RST_LASTING_MS;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_THRESHOLD:  thr_r      <= cfg_data[PWR_W-1:0];
        REG_SOUND_STEP: snd_step_r <= cfg_data[STEP_W-1:0];
        REG_SIL_STEP:   sil_step_r <= cfg_data[STEP_W-1:0];
        REG_FLOOR:      floor_r    <= cfg_data[INTEG_W-1:0];
        REG_CEILING:    ceil_r     <= cfg_data[INTEG_W-1:0];
        REG_ON_LEVEL:   on_lvl_r   <= cfg_data[INTEG_W-1:0];
        REG_OFF_LEVEL:  off_lvl_r  <= cfg_data[INTEG_W-1:0];
        REG_LASTING_MS: last_ms_r  <= cfg_data[TIME_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // a taken request always starts the multiply step
  `SAD_ASSERT_NEXT(a_accept_starts, in_valid && in_ready, seq_r == SQ_MUL)
  // divider counter never runs past the last quotient bit
  `SAD_ASSERT_NOW(a_div_cnt_range, seq_r == SQ_DIV, cnt_r <= DIV_CNT_W'(DIV_STEPS - 1))
  // the integrator never ends above the ceiling after a request
  `SAD_ASSERT_NEXT(a_integ_ceiling, seq_r == SQ_FIN && out_free, integ_r <= ceil_r)
  // a result is only loaded when the sequencer finishes
  `SAD_ASSERT_NOW(a_out_from_fin, out_valid_nxt && !out_valid_r, seq_r == SQ_FIN)

endmodule
